### sv/ntt_pkg.sv
package ntt_pkg;

   localparam int ENTRIES_DEF = 64;

   localparam logic [1:0] OP_OUT  = 2'd0;
   localparam logic [1:0] OP_IN   = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_RSVD = 2'd3;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_NO_PORT = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_IN_MISS = 3'd4;
   localparam logic [2:0] ST_TICK    = 3'd5;

   localparam logic [1:0] REG_PUBLIC_IP = 2'd0;
   localparam logic [1:0] REG_TIMEOUT   = 2'd1;
   localparam logic [1:0] REG_PORT_MIN  = 2'd2;
   localparam logic [1:0] REG_PORT_MAX  = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] client_ip;
      logic [15:0] host_port;
      logic [31:0] tunnel_ip;
      logic [15:0] tunnel_port;
      logic [15:0] public_port;
      logic [31:0] touch_time;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_SWEEP,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic shift;
      logic last;
   } ring_ctl_type;

endpackage

### sv/ntt_req_if.sv
interface ntt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] item_ip;
   logic [15:0] item_port;
   logic [31:0] tunnel_ip;
   logic [15:0] tunnel_port;
   modport source (output valid, op, item_ip, item_port, tunnel_ip, tunnel_port,
                   input ready);
   modport sink (input valid, op, item_ip, item_port, tunnel_ip, tunnel_port,
                 output ready);
endinterface

### sv/ntt_rsp_if.sv
interface ntt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] res_ip;
   logic [15:0] res_port;
   logic [31:0] res_tunnel_ip;
   logic [15:0] res_tunnel_port;
   modport source (output valid, status, res_ip, res_port, res_tunnel_ip,
                   res_tunnel_port, input ready);
   modport sink (input valid, status, res_ip, res_port, res_tunnel_ip,
                 res_tunnel_port, output ready);
endinterface

### sv/ntt_cell.sv
module ntt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  ntt_pkg::entry_type nbr_in,
   input  logic               wr_en,
   input  ntt_pkg::entry_type wr_data,
   output ntt_pkg::entry_type entry
);

   ntt_pkg::entry_type entry_ff;
   ntt_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in = wr_data;
      end else if (shift) begin
         entry_in = nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### sv/nat_translation_table.sv
// Port-translation table built as a ring of ENTRIES cells; the head cell is examined
// while the ring rotates one slot per cycle during the match and sweep passes.
// A tick answers directly; inbound and outbound items make a match pass round the ring;
// an outbound miss adds a sweep pass and, if a slot is free, a port scan. One item in flight at a time.
// Reset (synchronous, active high): all entries invalid, time zero, registers at
// defaults (timeout 60, port range 1024..65534).
module nat_translation_table #(
   parameter int ENTRIES = ntt_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ntt_req_if.sink     req,
   ntt_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [KW-1:0] K_LAST   = KW'(ENTRIES);
   localparam logic [15:0]   SPAN     = 16'(ENTRIES);

   // ---------------- configuration registers ----------------
   logic [31:0] public_ip_ff, timeout_ff;
   logic [15:0] port_min_ff, port_max_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         public_ip_ff <= '0;
         timeout_ff   <= 32'd60;
         port_min_ff  <= 16'd1024;
         port_max_ff  <= 16'd65534;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            ntt_pkg::REG_PUBLIC_IP: public_ip_ff <= csr_pwdata;
            ntt_pkg::REG_TIMEOUT:   timeout_ff   <= csr_pwdata;
            ntt_pkg::REG_PORT_MIN:  port_min_ff  <= csr_pwdata[15:0];
            ntt_pkg::REG_PORT_MAX:  port_max_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ntt_pkg::REG_PUBLIC_IP: csr_prdata = public_ip_ff;
         ntt_pkg::REG_TIMEOUT:   csr_prdata = timeout_ff;
         ntt_pkg::REG_PORT_MIN:  csr_prdata = {16'd0, port_min_ff};
         ntt_pkg::REG_PORT_MAX:  csr_prdata = {16'd0, port_max_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- control state ----------------
   ntt_pkg::state_type    state_ff, state_in;
   ntt_pkg::ring_ctl_type ctl;
   logic [IW-1:0]         cnt_ff;
   logic [KW-1:0]         k_ff;
   logic [31:0]           now_ff;

   // latched item
   logic [1:0]  op_ff;
   logic [31:0] ip_ff, tip_ff;
   logic [15:0] port_ff, tport_ff;
   logic        ip_ok_ff;

   // pass bookkeeping
   logic          hit_ff;
   logic          slot_found_ff;
   logic [IW-1:0] slot_ff;
   logic [ENTRIES:0] used_ff;     // bit k: port_min+k held by a live entry

   // staged result
   logic [2:0]  res_st_ff;
   logic [31:0] res_ip_ff, res_tip_ff;
   logic [15:0] res_port_ff, res_tport_ff;

   logic rsp_valid_ff;
   logic req_fire;
   assign req_fire  = req.valid & req.ready;
   assign req.ready = (state_ff == ntt_pkg::S_IDLE);

   // ---------------- cell ring ----------------
   ntt_pkg::entry_type cells [ENTRIES];
   ntt_pkg::entry_type head, head_out, new_entry;
   logic [31:0] head_age;
   logic        out_match, in_match, stale, live_after;
   logic [15:0] pub_diff;
   logic [16:0] cand_port;
   logic        scan_write;

   assign head      = cells[0];
   assign head_age  = now_ff - head.touch_time;
   assign out_match = head.valid && head.client_ip == ip_ff && head.host_port == port_ff
                      && head.tunnel_ip == tip_ff && head.tunnel_port == tport_ff;
   assign in_match  = head.valid && ip_ok_ff && head.public_port == port_ff
                      && head_age < timeout_ff;
   assign stale      = head.valid && head_age > timeout_ff;
   assign live_after = head.valid && !stale;
   assign pub_diff   = head.public_port - port_min_ff;
   assign cand_port  = {1'b0, port_min_ff} + 17'(k_ff);

   // head modification before the entry re-enters at the tail
   always_comb begin
      head_out = head;
      if (state_ff == ntt_pkg::S_MATCH && !hit_ff) begin
         if ((op_ff == ntt_pkg::OP_OUT && out_match) || (op_ff == ntt_pkg::OP_IN && in_match)) begin
            head_out.touch_time = now_ff;
         end
      end
      if (state_ff == ntt_pkg::S_SWEEP) begin
         head_out.valid = live_after;
      end
   end

   always_comb begin
      new_entry.valid       = 1'b1;
      new_entry.client_ip   = ip_ff;
      new_entry.host_port   = port_ff;
      new_entry.tunnel_ip   = tip_ff;
      new_entry.tunnel_port = tport_ff;
      new_entry.public_port = cand_port[15:0];
      new_entry.touch_time  = now_ff;
   end

   assign scan_write = (state_ff == ntt_pkg::S_SCAN) && (cand_port <= {1'b0, port_max_ff})
                       && !used_ff[0];

   for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
      ntt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (ctl.shift),
         .nbr_in  ((g == ENTRIES - 1) ? head_out : cells[(g + 1) % ENTRIES]),
         .wr_en   (scan_write && slot_ff == IW'(g)),
         .wr_data (new_entry),
         .entry   (cells[g])
      );
   end

   // ---------------- FSM ----------------
   always_comb begin
      ctl.shift = (state_ff == ntt_pkg::S_MATCH) || (state_ff == ntt_pkg::S_SWEEP);
      ctl.last  = (cnt_ff == LAST_IDX);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntt_pkg::S_IDLE: begin
            if (req_fire) begin
               priority if (req.op == ntt_pkg::OP_TICK) state_in = ntt_pkg::S_RESP;
               else if (req.op == ntt_pkg::OP_OUT || req.op == ntt_pkg::OP_IN)
                  state_in = ntt_pkg::S_MATCH;
               else state_in = ntt_pkg::S_IDLE;
            end
         end
         ntt_pkg::S_MATCH: begin
            if (ctl.last) begin
               if (hit_ff || (op_ff == ntt_pkg::OP_OUT && out_match)
                   || op_ff != ntt_pkg::OP_OUT) begin
                  state_in = ntt_pkg::S_RESP;
               end else begin
                  state_in = ntt_pkg::S_SWEEP;
               end
            end
         end
         ntt_pkg::S_SWEEP: begin
            if (ctl.last) begin
               state_in = (slot_found_ff || !live_after) ? ntt_pkg::S_SCAN : ntt_pkg::S_RESP;
            end
         end
         ntt_pkg::S_SCAN: begin
            if (cand_port > {1'b0, port_max_ff} || !used_ff[0] || k_ff == K_LAST) begin
               state_in = ntt_pkg::S_RESP;
            end
         end
         ntt_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ntt_pkg::S_IDLE;
         end
         default: state_in = ntt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath sequencing ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         now_ff        <= '0;
         hit_ff        <= 1'b0;
         slot_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // a beat taken by the sink frees the output unless a new one loads now
         if (rsp_valid_ff && rsp.ready && state_ff != ntt_pkg::S_RESP) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ntt_pkg::S_IDLE: begin
               cnt_ff        <= '0;
               hit_ff        <= 1'b0;
               slot_found_ff <= 1'b0;
               if (req_fire) begin
                  op_ff    <= req.op;
                  ip_ff    <= req.item_ip;
                  port_ff  <= req.item_port;
                  tip_ff   <= req.tunnel_ip;
                  tport_ff <= req.tunnel_port;
                  ip_ok_ff <= (req.item_ip == public_ip_ff);
                  res_st_ff    <= ntt_pkg::ST_TICK;
                  res_ip_ff    <= '0;
                  res_port_ff  <= '0;
                  res_tip_ff   <= '0;
                  res_tport_ff <= '0;
                  if (req.op == ntt_pkg::OP_TICK) now_ff <= now_ff + 32'd1;
               end
            end
            ntt_pkg::S_MATCH: begin
               cnt_ff <= ctl.last ? '0 : cnt_ff + IW'(1);
               if (!hit_ff && op_ff == ntt_pkg::OP_OUT && out_match) begin
                  hit_ff      <= 1'b1;
                  res_st_ff   <= ntt_pkg::ST_HIT;
                  res_ip_ff   <= public_ip_ff;
                  res_port_ff <= head.public_port;
               end
               if (!hit_ff && op_ff == ntt_pkg::OP_IN && in_match) begin
                  hit_ff       <= 1'b1;
                  res_st_ff    <= ntt_pkg::ST_HIT;
                  res_ip_ff    <= head.client_ip;
                  res_port_ff  <= head.host_port;
                  res_tip_ff   <= head.tunnel_ip;
                  res_tport_ff <= head.tunnel_port;
               end
               if (ctl.last && !hit_ff && !(op_ff == ntt_pkg::OP_OUT && out_match)
                   && !(op_ff == ntt_pkg::OP_IN && in_match)) begin
                  res_st_ff <= (op_ff == ntt_pkg::OP_IN) ? ntt_pkg::ST_IN_MISS : ntt_pkg::ST_FULL;
                  used_ff   <= '0;
               end
            end
            ntt_pkg::S_SWEEP: begin
               cnt_ff <= ctl.last ? '0 : cnt_ff + IW'(1);
               k_ff   <= '0;
               if (!live_after && !slot_found_ff) begin
                  slot_found_ff <= 1'b1;
                  slot_ff       <= cnt_ff;
               end
               if (live_after && head.public_port >= port_min_ff && pub_diff <= SPAN) begin
                  used_ff[pub_diff[KW-1:0]] <= 1'b1;
               end
            end
            ntt_pkg::S_SCAN: begin
               used_ff <= used_ff >> 1;
               k_ff    <= k_ff + KW'(1);
               if (scan_write) begin
                  res_st_ff   <= ntt_pkg::ST_NEW;
                  res_ip_ff   <= public_ip_ff;
                  res_port_ff <= cand_port[15:0];
               end else begin
                  res_st_ff <= ntt_pkg::ST_NO_PORT;
               end
            end
            ntt_pkg::S_RESP: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp.status          <= res_st_ff;
                  rsp.res_ip          <= res_ip_ff;
                  rsp.res_port        <= res_port_ff;
                  rsp.res_tunnel_ip   <= res_tip_ff;
                  rsp.res_tunnel_port <= res_tport_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ntt_pkg::S_IDLE |-> cnt_ff == '0) else $error("ring count not parked");
   a_scan_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ntt_pkg::S_SCAN |-> slot_found_ff) else $error("scan without free slot");
   a_tick_resp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.op == ntt_pkg::OP_TICK |=> state_ff == ntt_pkg::S_RESP)
      else $error("tick not answered");
   a_no_shift_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ntt_pkg::S_IDLE |-> !ctl.shift) else $error("ring moved while idle");
`endif

endmodule

### test/ntt_checker.sv
module ntt_checker (
   input  logic  clock,
   input  logic  reset,
   ntt_req_if    req,
   ntt_rsp_if    rsp,
   input  logic  cfg_we,
   input  logic [1:0]  cfg_idx,
   input  logic [31:0] cfg_val,
   output int    fail_count,
   output int    pending
);

   localparam int N = ntt_pkg::ENTRIES_DEF;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] tip;
      logic [15:0] tport;
   } answer_type;

   logic [31:0] pub_ip, tmo;
   logic [15:0] pmin, pmax;
   logic [31:0] now;
   ntt_pkg::entry_type tbl [N];
   answer_type  answers [$];

   function automatic logic port_taken(logic [15:0] p);
      for (int i = 0; i < N; i++)
         if (tbl[i].valid && tbl[i].public_port == p) return 1'b1;
      return 1'b0;
   endfunction

   // advances the shadow table by one beat and returns what the block owes
   function automatic answer_type translate(logic [1:0] op, logic [31:0] ip,
                                           logic [15:0] port, logic [31:0] tip,
                                           logic [15:0] tport);
      answer_type a;
      int slot;
      logic [16:0] p;
      logic found;
      a = '0;
      slot = -1;
      found = 1'b0;
      p = '0;
      if (op == ntt_pkg::OP_TICK) begin
         now = now + 32'd1;
         a.status = ntt_pkg::ST_TICK;
         return a;
      end
      if (op == ntt_pkg::OP_IN) begin
         a.status = ntt_pkg::ST_IN_MISS;
         if (ip == pub_ip)
            for (int i = 0; i < N; i++)
               if (tbl[i].valid && tbl[i].public_port == port &&
                   (now - tbl[i].touch_time) < tmo) begin
                  tbl[i].touch_time = now;
                  a.status = ntt_pkg::ST_HIT;
                  a.ip = tbl[i].client_ip;
                  a.port = tbl[i].host_port;
                  a.tip = tbl[i].tunnel_ip;
                  a.tport = tbl[i].tunnel_port;
                  return a;
               end
         return a;
      end
      for (int i = 0; i < N; i++)
         if (tbl[i].valid && tbl[i].client_ip == ip && tbl[i].host_port == port &&
             tbl[i].tunnel_ip == tip && tbl[i].tunnel_port == tport) begin
            tbl[i].touch_time = now;
            a.status = ntt_pkg::ST_HIT;
            a.ip = pub_ip;
            a.port = tbl[i].public_port;
            return a;
         end
      for (int i = 0; i < N; i++)
         if (tbl[i].valid && (now - tbl[i].touch_time) > tmo) tbl[i].valid = 1'b0;
      for (int i = 0; i < N; i++)
         if (!tbl[i].valid) begin
            slot = i;
            break;
         end
      if (slot < 0) begin
         a.status = ntt_pkg::ST_FULL;
         return a;
      end
      for (int k = 0; k <= N; k++) begin
         p = {1'b0, pmin} + 17'(k);
         if (p > {1'b0, pmax}) break;
         if (!port_taken(p[15:0])) begin
            found = 1'b1;
            break;
         end
      end
      if (!found) begin
         a.status = ntt_pkg::ST_NO_PORT;
         return a;
      end
      tbl[slot] = '{1'b1, ip, port, tip, tport, p[15:0], now};
      a.status = ntt_pkg::ST_NEW;
      a.ip = pub_ip;
      a.port = p[15:0];
      return a;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type w;
      if (reset) begin
         pub_ip = 32'd0; tmo = 32'd60; pmin = 16'd1024; pmax = 16'd65534; now = 32'd0;
         for (int i = 0; i < N; i++) tbl[i].valid = 1'b0;
         answers.delete();
         fail_count = 0;
      end else begin
         if (cfg_we)
            unique case (cfg_idx)
               ntt_pkg::REG_PUBLIC_IP: pub_ip = cfg_val;
               ntt_pkg::REG_TIMEOUT:   tmo = cfg_val;
               ntt_pkg::REG_PORT_MIN:  pmin = cfg_val[15:0];
               ntt_pkg::REG_PORT_MAX:  pmax = cfg_val[15:0];
            endcase
         if (req.valid && req.ready && req.op != ntt_pkg::OP_RSVD)
            answers.push_back(translate(req.op, req.item_ip, req.item_port,
                                        req.tunnel_ip, req.tunnel_port));
         if (rsp.valid && rsp.ready) begin
            if (answers.size() == 0) report("unexpected beat", 32'(rsp.status), 32'd0);
            else begin
               w = answers.pop_front();
               if (rsp.status !== w.status)
                  report("status", 32'(rsp.status), 32'(w.status));
               if (rsp.res_ip !== w.ip) report("res_ip", rsp.res_ip, w.ip);
               if (rsp.res_port !== w.port)
                  report("res_port", 32'(rsp.res_port), 32'(w.port));
               if (rsp.res_tunnel_ip !== w.tip)
                  report("res_tunnel_ip", rsp.res_tunnel_ip, w.tip);
               if (rsp.res_tunnel_port !== w.tport)
                  report("res_tunnel_port", 32'(rsp.res_tunnel_port), 32'(w.tport));
            end
         end
      end
      pending = answers.size();
   end
endmodule

### test/nat_translation_table_tb.sv
module nat_translation_table_tb;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   ntt_req_if req ();
   ntt_rsp_if rsp ();

   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending;
   bit hold_off = 0;      // long receiver stall request

   // mirror of the client pool so most outbound beats revisit known flows
   logic [31:0] pool_ip [8];
   logic [15:0] pool_port [8];
   logic [15:0] last_pub;
   logic [31:0] cur_pub;

   nat_translation_table i_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   // config writes land when psel&penable&pwrite&pready
   ntt_checker i_chk (
      .clock, .reset, .req(req), .rsp(rsp),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_idx(csr_paddr[3:2]), .cfg_val(csr_pwdata),
      .fail_count, .pending
   );

   initial begin
      req.valid = 0; req.op = ntt_pkg::OP_OUT; req.item_ip = 0; req.item_port = 0;
      req.tunnel_ip = 0; req.tunnel_port = 0;
      rsp.ready = 0;
   end

   // receiver: own stall pattern, plus the long hold-off
   initial begin
      int mode;
      mode = 0;
      forever begin
         @(posedge clock);
         if (($urandom & 63) == 0) mode = $urandom_range(0, 2);
         if (hold_off) rsp.ready <= 1'b0;
         else case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom & 3) != 0;
            default: rsp.ready <= ($urandom & 3) == 0;
         endcase
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == ntt_pkg::REG_PUBLIC_IP) cur_pub = val;
   endtask

   // one beat on the input channel; valid stays high across back-to-back beats when keep is set
   task automatic send(logic [1:0] op, logic [31:0] ip, logic [15:0] port,
                       logic [31:0] tip, logic [15:0] tport, bit keep);
      req.valid <= 1; req.op <= op; req.item_ip <= ip; req.item_port <= port;
      req.tunnel_ip <= tip; req.tunnel_port <= tport;
      do @(posedge clock); while (!req.ready);
      if (!keep) req.valid <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (3 * ntt_pkg::ENTRIES_DEF + 20) @(posedge clock);
   endtask

   // random beat: pool flows are the largest share, inbound aimed at allocated ports
   task automatic random_beat(bit keep);
      int r, k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (r < 40)
         send(ntt_pkg::OP_OUT, pool_ip[k], pool_port[k], pool_ip[k] ^ 32'h5a5a,
              ~pool_port[k], keep);
      else if (r < 55)
         send(ntt_pkg::OP_OUT, 32'($urandom), 16'($urandom), 32'($urandom),
              16'($urandom), keep);
      else if (r < 75)
         send(ntt_pkg::OP_IN, (($urandom & 7) != 0) ? cur_pub : 32'($urandom),
              last_pub + 16'($urandom_range(0, 12)), 32'($urandom), 16'($urandom), keep);
      else if (r < 97)
         send(ntt_pkg::OP_TICK, 32'($urandom), 16'($urandom), 32'($urandom),
              16'($urandom), keep);
      else
         send(ntt_pkg::OP_RSVD, 32'($urandom), 16'($urandom), 32'($urandom),
              16'($urandom), keep);
   endtask

   task automatic random_phase(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && n > 0) begin
            random_beat(burst > 1 && n > 1);
            burst--; n--;
         end
         repeat ($urandom_range(0, 40)) @(posedge clock);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         pool_ip[i] = $urandom; pool_port[i] = 16'($urandom);
      end
      cur_pub = 0;
      last_pub = 16'd1024;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: defaults, then extremes of every field
      send(ntt_pkg::OP_OUT, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 1'b0);
      send(ntt_pkg::OP_OUT, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_OUT, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);  // hit
      send(ntt_pkg::OP_IN, 32'h0, 16'd1024, 32'h0, 16'h0, 1'b0); // inbound hit, public ip 0
      send(ntt_pkg::OP_IN, 32'h1, 16'd1024, 32'h0, 16'h0, 1'b0); // wrong public ip
      send(ntt_pkg::OP_IN, 32'h0, 16'hffff, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_RSVD, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 1'b0); // ignored
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      drain();

      // age past timeout: stale entries miss inbound but still match outbound
      csr_write(ntt_pkg::REG_TIMEOUT, 32'd2);
      csr_write(ntt_pkg::REG_PUBLIC_IP, 32'hffffffff);
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b1);
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_IN, 32'hffffffff, 16'd1024, 32'h0, 16'h0, 1'b0);  // age 3: miss
      send(ntt_pkg::OP_OUT, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);   // stale-ish match still hits
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_OUT, 32'h7, 16'h7, 32'h7, 16'h7, 1'b0);   // sweeps stale entries
      drain();

      // empty range and exhausted range
      csr_write(ntt_pkg::REG_PORT_MIN, 32'h0000ffff);
      csr_write(ntt_pkg::REG_PORT_MAX, 32'h0);
      send(ntt_pkg::OP_OUT, 32'h11, 16'h11, 32'h0, 16'h0, 1'b0);
      drain();
      csr_write(ntt_pkg::REG_PORT_MIN, 32'h0000fffe);
      csr_write(ntt_pkg::REG_PORT_MAX, 32'h0000ffff);
      csr_write(ntt_pkg::REG_TIMEOUT, 32'hffffffff);
      for (int i = 0; i < 4; i++)
         send(ntt_pkg::OP_OUT, 32'h20 + 32'(i), 16'(i), 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_IN, 32'hffffffff, 16'hffff, 32'h0, 16'h0, 1'b0);
      drain();

      // zero timeout, then a full table with a port range it never exhausts
      csr_write(ntt_pkg::REG_TIMEOUT, 32'h0);
      csr_write(ntt_pkg::REG_PORT_MIN, 32'h0);
      csr_write(ntt_pkg::REG_PORT_MAX, 32'h0000ffff);
      send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0);
      send(ntt_pkg::OP_IN, 32'hffffffff, 16'hfffe, 32'h0, 16'h0, 1'b0);
      drain();
      csr_write(ntt_pkg::REG_TIMEOUT, 32'hffffffff);
      for (int i = 0; i < ntt_pkg::ENTRIES_DEF + 2; i++)
         send(ntt_pkg::OP_OUT, 32'($urandom), 16'($urandom), 32'($urandom),
              16'($urandom), i < ntt_pkg::ENTRIES_DEF + 1);
      drain();

      // pressure: receiver holds off while sender keeps offering
      hold_off = 1;
      fork
         begin
            for (int i = 0; i < 6; i++)
               send(ntt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 16'h0, i < 5);
         end
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join
      drain();

      // random phases under a few settings; short timeouts make entries churn
      for (int ph = 0; ph < 5; ph++) begin
         cur_pub = $urandom;
         last_pub = (ph == 4) ? 16'hffc0 : 16'($urandom_range(0, 4000));
         csr_write(ntt_pkg::REG_PUBLIC_IP, cur_pub);
         csr_write(ntt_pkg::REG_TIMEOUT, (ph == 3) ? 32'd1 : 32'($urandom_range(3, 40)));
         csr_write(ntt_pkg::REG_PORT_MIN, {16'd0, last_pub});
         csr_write(ntt_pkg::REG_PORT_MAX, (ph == 4) ? 32'h0000ffff :
                   {16'd0, last_pub + 16'($urandom_range(4, 80))});
         random_phase(130);
         drain();
      end

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
